// ===== design/crc_framed_message_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// crc_framed_message_receiver_assert.svh
// Assertion macros shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_MESSAGE_RECEIVER_ASSERT_SVH
`define CRC_FRAMED_MESSAGE_RECEIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CFMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cfmr: implication check failed");

// next-cycle implication, checked out of reset
`define CFMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cfmr: next-cycle check failed");

`endif

// ===== design/cfmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfmr_pkg
// Types, codes and the byte-wide CRC-16-CCITT update for the frame receiver.
// ----------------------------------------------------------------------------
package cfmr_pkg;

	typedef enum logic [2:0] {
		PH_WAIT      = 3'd0,
		PH_ACK       = 3'd1,
		PH_LEN_LO    = 3'd2,
		PH_LEN_HI    = 3'd3,
		PH_DATA_RESP = 3'd4,
		PH_DATA_CMD  = 3'd5,
		PH_CRC_LO    = 3'd6,
		PH_CRC_HI    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_REJECT       = 3'd1,
		EV_RESP_OK      = 3'd2,
		EV_RESP_CORRUPT = 3'd3,
		EV_CRC_FAIL     = 3'd4,
		EV_CMD_OK       = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		REG_CMD_LIMIT    = 3'd0,
		REG_CONNECT_CODE = 3'd1,
		REG_MAX_LENGTH   = 3'd2,
		REG_CRC_LSB      = 3'd3
	} reg_idx_t;

	localparam logic [7:0]  ACK_DATA   = 8'h55;
	localparam logic [7:0]  ACK_NODATA = 8'hA5;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] MIN_LENGTH = 16'd3;
	localparam logic [15:0] CRC_BYTES  = 16'd2;

	localparam logic [7:0]  RST_CMD_LIMIT    = 8'd16;
	localparam logic [6:0]  RST_CONNECT_CODE = 7'd1;
	localparam logic [15:0] RST_MAX_LENGTH   = 16'd256;
	localparam logic        RST_CRC_LSB      = 1'b1;

	// one byte through the serial CRC, eight bit steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
			input logic lsb_first);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[15] ^ (lsb_first ? b[i] : b[7-i]);
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

// ===== design/crc_framed_message_receiver.sv =====
// ----------------------------------------------------------------------------
// crc_framed_message_receiver
// Frames serial bytes into response and command messages closed by a
// CRC-16-CCITT check and reports one result per byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        in         in_valid / in_stall   op, rx_byte
//  out       out        out_valid / out_stall event_res, data_*, payload_length,
//                                             command_code, command_data, is_connect
//  cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One byte per cycle sustained while the output is not stalled.
//  Bytes land in an input register; the framing state and CRC update when the
//  byte leaves it, as the result register loads, one byte-wide CRC step per byte.
//  A stall at the output backs up through both registers to in_stall.
//  arst_n resets the framing state, valid flags and configuration.
// ----------------------------------------------------------------------------
module crc_framed_message_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic [15:0] data_index,
	output logic [15:0] payload_length,
	output logic [6:0]  command_code,
	output logic [7:0]  command_data,
	output logic        is_connect,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cfmr_pkg::*;

	// configuration
	logic [7:0]  cmd_limit_q;
	logic [6:0]  connect_code_q;
	logic [15:0] max_length_q;
	logic        crc_lsb_q;

	// input stage
	logic        s1_valid_q;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        s1_adv;

	// framing state
	phase_t      phase_q, phase_d;
	logic [15:0] bytes_remaining_q, bytes_remaining_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;
	logic        armed_q, armed_d;
	logic [7:0]  expected_q, expected_d;
	logic [15:0] write_index_q, write_index_d;
	logic [15:0] frame_length_q, frame_length_d;
	logic [6:0]  held_cmd_q, held_cmd_d;
	logic [7:0]  held_data_q, held_data_d;

	// result
	logic        out_valid_q;
	event_t      ev_d, ev_q;
	logic        dv_d, dv_q;
	logic [7:0]  db_d, db_q;
	logic [15:0] di_d, di_q;
	logic [15:0] plen_d, plen_q;
	logic [6:0]  cc_d, cc_q;
	logic [7:0]  cd_d, cd_q;
	logic        conn_d, conn_q;

	logic [15:0] crc_fed;
	logic [15:0] len_full;
	logic [15:0] br_dec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_limit_q    <= RST_CMD_LIMIT;
			connect_code_q <= RST_CONNECT_CODE;
			max_length_q   <= RST_MAX_LENGTH;
			crc_lsb_q      <= RST_CRC_LSB;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CMD_LIMIT:    cmd_limit_q    <= cfg_data[7:0];
				REG_CONNECT_CODE: connect_code_q <= cfg_data[6:0];
				REG_MAX_LENGTH:   max_length_q   <= cfg_data;
				REG_CRC_LSB:      crc_lsb_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the input register moves on whenever the result register is free or draining
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	assign crc_fed  = crc_feed((phase_q == PH_WAIT) ? CRC_INIT : crc_q, byte_s1, crc_lsb_q);
	assign len_full = {byte_s1, bytes_remaining_q[7:0]};
	assign br_dec   = bytes_remaining_q - 16'd1;

	always_comb begin
		phase_d           = phase_q;
		bytes_remaining_d = bytes_remaining_q;
		crc_d             = crc_q;
		crc_low_d         = crc_low_q;
		armed_d           = armed_q;
		expected_d        = expected_q;
		write_index_d     = write_index_q;
		frame_length_d    = frame_length_q;
		held_cmd_d        = held_cmd_q;
		held_data_d       = held_data_q;
		ev_d              = EV_NONE;
		dv_d              = 1'b0;
		db_d              = '0;
		di_d              = '0;
		plen_d            = '0;
		cc_d              = '0;
		cd_d              = '0;
		conn_d            = 1'b0;
		if (op_s1) begin
			expected_d = {1'b1, byte_s1[6:0]};
			armed_d    = 1'b1;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (armed_q && byte_s1[7] && byte_s1 == expected_q) begin
						phase_d        = PH_ACK;
						frame_length_d = '0;
						crc_d          = crc_fed;
					end else if (!byte_s1[7] && byte_s1 < cmd_limit_q) begin
						phase_d        = PH_DATA_CMD;
						held_cmd_d     = byte_s1[6:0];
						frame_length_d = '0;
						crc_d          = crc_fed;
					end else begin
						ev_d = EV_REJECT;
					end
				end
				PH_ACK: begin
					if (byte_s1 == ACK_DATA) begin
						phase_d = PH_LEN_LO;
						crc_d   = crc_fed;
					end else if (byte_s1 == ACK_NODATA) begin
						ev_d    = EV_RESP_OK;
						armed_d = 1'b0;
						phase_d = PH_WAIT;
						crc_d   = crc_fed;
					end else begin
						ev_d    = EV_RESP_CORRUPT;
						armed_d = 1'b0;
						phase_d = PH_WAIT;
					end
				end
				PH_LEN_LO: begin
					bytes_remaining_d = {8'd0, byte_s1};
					crc_d             = crc_fed;
					phase_d           = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					bytes_remaining_d = len_full;
					if (len_full >= MIN_LENGTH && len_full <= max_length_q) begin
						frame_length_d = len_full;
						write_index_d  = '0;
						crc_d          = crc_fed;
						phase_d        = PH_DATA_RESP;
					end else begin
						ev_d    = EV_RESP_CORRUPT;
						armed_d = 1'b0;
						phase_d = PH_WAIT;
					end
				end
				PH_DATA_RESP: begin
					dv_d              = 1'b1;
					db_d              = byte_s1;
					di_d              = write_index_q;
					write_index_d     = write_index_q + 16'd1;
					crc_d             = crc_fed;
					bytes_remaining_d = br_dec;
					if (br_dec <= CRC_BYTES) begin
						phase_d = PH_CRC_LO;
					end
				end
				PH_DATA_CMD: begin
					held_data_d = byte_s1;
					crc_d       = crc_fed;
					phase_d     = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					crc_low_d = byte_s1;
					phase_d   = PH_CRC_HI;
				end
				default: begin
					// frame length zero marks a command frame
					if (frame_length_q != '0) begin
						if ({byte_s1, crc_low_q} == crc_q) begin
							ev_d   = EV_RESP_OK;
							plen_d = frame_length_q - CRC_BYTES;
						end else begin
							ev_d = EV_CRC_FAIL;
						end
						armed_d = 1'b0;
					end else if ({byte_s1, crc_low_q} == crc_q) begin
						ev_d   = EV_CMD_OK;
						cc_d   = held_cmd_q;
						cd_d   = held_data_q;
						conn_d = (held_cmd_q == connect_code_q);
					end
					phase_d = PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_WAIT;
			bytes_remaining_q <= '0;
			crc_q             <= CRC_INIT;
			crc_low_q         <= '0;
			armed_q           <= 1'b0;
			expected_q        <= '0;
			write_index_q     <= '0;
			frame_length_q    <= '0;
			held_cmd_q        <= '0;
			held_data_q       <= '0;
		end else if (s1_adv) begin
			phase_q           <= phase_d;
			bytes_remaining_q <= bytes_remaining_d;
			crc_q             <= crc_d;
			crc_low_q         <= crc_low_d;
			armed_q           <= armed_d;
			expected_q        <= expected_d;
			write_index_q     <= write_index_d;
			frame_length_q    <= frame_length_d;
			held_cmd_q        <= held_cmd_d;
			held_data_q       <= held_data_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ev_q   <= ev_d;
			dv_q   <= dv_d;
			db_q   <= db_d;
			di_q   <= di_d;
			plen_q <= plen_d;
			cc_q   <= cc_d;
			cd_q   <= cd_d;
			conn_q <= conn_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = ev_q;
	assign data_valid     = dv_q;
	assign data_byte      = db_q;
	assign data_index     = di_q;
	assign payload_length = plen_q;
	assign command_code   = cc_q;
	assign command_data   = cd_q;
	assign is_connect     = conn_q;

`include "crc_framed_message_receiver_assert.svh"

	`CFMR_ASSERT_IMPLY(a_data_in_range, clk, arst_n, phase_q == PH_DATA_RESP,
		bytes_remaining_q >= MIN_LENGTH)
	`CFMR_ASSERT_IMPLY(a_connect_on_cmd, clk, arst_n, out_valid_q && conn_q,
		ev_q == EV_CMD_OK)
	`CFMR_ASSERT_IMPLY(a_data_no_event, clk, arst_n, out_valid_q && dv_q,
		ev_q == EV_NONE)
	`CFMR_ASSERT_IMPLY(a_stall_needs_full, clk, arst_n, in_stall,
		s1_valid_q && out_valid_q && out_stall)
	`CFMR_ASSERT_NEXT(a_result_follows, clk, arst_n, s1_adv, out_valid_q)

endmodule
